// ===== design/assert_macros.svh =====
// Assertion macros used by the decode module of the decoder.
// Needs signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define U8SD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define U8SD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/u8sd_pkg.sv =====
// Types and constants of the UTF-8 stream decoder.
// No dependencies.
package u8sd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEFT_W = 10;
  localparam int CP_W   = 21;

  localparam logic [CP_W-1:0]   REPLACEMENT_CHAR = 21'h00FFFD;
  localparam logic [BYTE_W-1:0] CONT_TAG         = 8'h80;
  localparam logic [BYTE_W-1:0] TAG2_MASK        = 8'hC0;
  localparam logic [BYTE_W-1:0] TAG3_MASK        = 8'hE0;
  localparam logic [BYTE_W-1:0] TAG4_MASK        = 8'hF0;
  localparam logic [BYTE_W-1:0] TAG5_MASK        = 8'hF8;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic [LEFT_W-1:0] bytes_left;
  } item_t;

  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] char_code;
    logic            replaced;
  } result_t;

endpackage

// ===== design/u8sd_if.sv =====
// Handshake channels of the decoder: text bytes in, code points out.
// Depends on u8sd_pkg for field widths.
interface u8sd_byte_if import u8sd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic [LEFT_W-1:0] bytes_left;

  modport source (output valid, output in_byte, output bytes_left, input ready);
  modport sink   (input valid, input in_byte, input bytes_left, output ready);
endinterface

interface u8sd_cp_if import u8sd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] char_code;
  logic            replaced;

  modport source (output valid, output char_code, output replaced, input ready);
  modport sink   (input valid, input char_code, input replaced, output ready);
endinterface

// ===== design/u8sd_input_reg.sv =====
// Input register of the decoder: holds one text byte item until decoded.
// Depends on u8sd_pkg and u8sd_byte_if.
module u8sd_input_reg import u8sd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  u8sd_byte_if.sink    text,
  input  logic         advance,
  output logic         held,
  output item_t        item
);

  logic held_next;

  assign text.ready = !held || advance;

  always_comb begin
    held_next = held;
    if (text.valid && text.ready) begin
      held_next = 1'b1;
    end else if (advance) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      item.in_byte    <= text.in_byte;
      item.bytes_left <= text.bytes_left;
    end
  end

endmodule

// ===== design/u8sd_decode.sv =====
// Decode logic and sequence state: turns the held item into at most one result.
// Depends on u8sd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8sd_decode import u8sd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    held,
  input  item_t   item,
  input  logic    advance,
  output result_t res
);

  logic [1:0]      pending;
  logic [1:0]      pending_next;
  logic [CP_W-1:0] partial_value;
  logic [CP_W-1:0] partial_value_next;
  logic            swallowing;
  logic            swallowing_next;

  logic [CP_W-1:0] gathered;
  logic [1:0]      need;
  logic [CP_W-1:0] lead_value;
  logic            lead_ok;
  logic            last_byte;

  assign last_byte = (item.bytes_left == '0);
  assign gathered  = {partial_value[CP_W-7:0], item.in_byte[5:0]};

  always_comb begin
    need       = 2'd0;
    lead_value = '0;
    lead_ok    = 1'b1;
    if ((item.in_byte & TAG3_MASK) == TAG2_MASK) begin
      need       = 2'd1;
      lead_value = {{(CP_W-5){1'b0}}, item.in_byte[4:0]};
    end else if ((item.in_byte & TAG4_MASK) == TAG3_MASK) begin
      need       = 2'd2;
      lead_value = {{(CP_W-4){1'b0}}, item.in_byte[3:0]};
    end else if ((item.in_byte & TAG5_MASK) == TAG4_MASK) begin
      need       = 2'd3;
      lead_value = {{(CP_W-3){1'b0}}, item.in_byte[2:0]};
    end else begin
      lead_ok    = 1'b0;
    end
  end

  always_comb begin
    pending_next       = pending;
    partial_value_next = partial_value;
    swallowing_next    = swallowing;
    res.emit           = 1'b0;
    res.char_code      = REPLACEMENT_CHAR;
    res.replaced       = 1'b1;
    if (swallowing) begin
      if (last_byte) begin
        swallowing_next = 1'b0;
      end
    end else if (pending != 2'd0) begin
      if ((item.in_byte & TAG2_MASK) != CONT_TAG) begin
        pending_next       = 2'd0;
        partial_value_next = '0;
        res.emit           = 1'b1;
      end else if (pending == 2'd1) begin
        pending_next       = 2'd0;
        partial_value_next = '0;
        res.emit           = 1'b1;
        res.char_code      = gathered;
        res.replaced       = 1'b0;
      end else if (last_byte) begin
        pending_next       = 2'd0;
        partial_value_next = '0;
        res.emit           = 1'b1;
      end else begin
        pending_next       = pending - 2'd1;
        partial_value_next = gathered;
      end
    end else if (!item.in_byte[7]) begin
      res.emit      = 1'b1;
      res.char_code = {{(CP_W-BYTE_W){1'b0}}, item.in_byte};
      res.replaced  = 1'b0;
    end else if (!lead_ok) begin
      res.emit = 1'b1;
    end else if ({{(LEFT_W-2){1'b0}}, need} > item.bytes_left) begin
      res.emit        = 1'b1;
      swallowing_next = !last_byte;
    end else begin
      pending_next       = need;
      partial_value_next = lead_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 2'd0;
      partial_value <= '0;
      swallowing    <= 1'b0;
    end else if (advance) begin
      pending       <= pending_next;
      partial_value <= partial_value_next;
      swallowing    <= swallowing_next;
    end
  end

  `U8SD_ASSERT(a_no_open_while_swallowing, !(swallowing && (pending != 2'd0)),
    "sequence open while swallowing")
  `U8SD_ASSERT(a_closed_clears_value, (pending != 2'd0) || (partial_value == '0),
    "stale partial value")
  `U8SD_ASSERT(a_emit_closes_sequence, (advance && held && res.emit) |=> (pending == 2'd0),
    "result left sequence open")
  `U8SD_ASSERT(a_replaced_value,
    (held && res.emit && res.replaced) |-> (res.char_code == REPLACEMENT_CHAR),
    "replacement with wrong code point")
  `U8SD_ASSERT_ALWAYS(a_reset_state, rst |=> ((pending == 2'd0) && !swallowing),
    "state not cleared by reset")

endmodule

// ===== design/u8sd_output_reg.sv =====
// Result register of the decoder: holds one code point item for the sink.
// Depends on u8sd_pkg and u8sd_cp_if.
module u8sd_output_reg import u8sd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  output logic       free,
  u8sd_cp_if.source  points
);

  logic full;
  logic full_next;

  assign free         = !full || points.ready;
  assign points.valid = full;

  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (points.ready) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      points.char_code <= res.char_code;
      points.replaced  <= res.replaced;
    end
  end

endmodule

// ===== design/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder: one text byte item in, at most one code point item out.
// A result is valid once the result register loads it from the held input item.
// Throughput: one byte per cycle, set by the single decode pass between the
// input register and the result register; a stalled result holds only bytes that emit.
// Reset (synchronous, rst high) closes any sequence and ends swallowing at once.
// Depends on u8sd_pkg, u8sd_if, u8sd_input_reg, u8sd_decode, u8sd_output_reg.
module utf8_stream_decoder_unit import u8sd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  u8sd_byte_if.sink  text,
  u8sd_cp_if.source  points
);

  logic    held;
  logic    advance;
  logic    out_free;
  item_t   item;
  result_t res;

  assign advance = held && (!res.emit || out_free);

  u8sd_input_reg u_input (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .advance (advance),
    .held    (held),
    .item    (item)
  );

  u8sd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .held    (held),
    .item    (item),
    .advance (advance),
    .res     (res)
  );

  u8sd_output_reg u_output (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && res.emit),
    .res    (res),
    .free   (out_free),
    .points (points)
  );

endmodule
